// ----- src/assert_macros.svh -----
// Assertion helpers for the queue unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/tsdq_pkg.sv -----
// ----------------------------------------------------------------------------
// tsdq_pkg
// Widths, codes and shared types of the timestamp delay release queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tsdq_pkg;

   localparam int TIME_W        = 48;
   localparam int PAY_W         = 32;
   localparam int REG_W         = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int DEPTH_DEFAULT = 8;

   localparam logic [REG_W-1:0] STALE_RESET = REG_W'(1000);

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STALE = CSR_IDX_W'(1);

   localparam logic REQ_PUSH  = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic              shift;
      logic [TIME_W-1:0] stamp;
      logic [PAY_W-1:0]  pay;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- src/tsdq_cell.sv -----
// ----------------------------------------------------------------------------
// tsdq_cell
// One queue slot: takes a new entry on load, else its upstream neighbor's
// entry on shift, else holds.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdq_cell
   import tsdq_pkg::*;
(
   input  wire logic              clock,
   input  wire cell_cmd_type      cmd,
   input  wire logic              load_en,
   input  wire logic [TIME_W-1:0] up_stamp,
   input  wire logic [PAY_W-1:0]  up_pay,
   output logic      [TIME_W-1:0] stamp,
   output logic      [PAY_W-1:0]  pay
);

   logic [TIME_W-1:0] stamp_ff, stamp_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;

   always_comb begin
      stamp_in = stamp_ff;
      pay_in   = pay_ff;
      priority if (load_en) begin
         stamp_in = cmd.stamp;
         pay_in   = cmd.pay;
      end else if (cmd.shift) begin
         stamp_in = up_stamp;
         pay_in   = up_pay;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      pay_ff   <= pay_in;
   end

   assign stamp = stamp_ff;
   assign pay   = pay_ff;

endmodule

`default_nettype wire

// ----- src/timestamp_delay_release_queue_unit.sv -----
// Timestamp delay release queue. Pushes append (timestamp, handle) pairs to a
// chain of QUEUE_DEPTH cells whose head is cell 0; a push to a full queue drops
// the oldest entry. A push gives no response. After a frame request is taken,
// req_stall stays high while the head cell is tested once per cycle and popped
// while it is ready, the whole chain shifting toward the head, until one test
// finds the head not ready or the queue empty; then ST_FINISH applies the stale
// check and loads the response register that drives rsp_valid, and it also
// waits while an earlier response is still held by rsp_stall. Requests are not
// taken while a frame is being drained; a response waiting on rsp_stall does
// not block further pushes.
`default_nettype none

`include "assert_macros.svh"

module timestamp_delay_release_queue_unit
   import tsdq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEPTH_DEFAULT
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_type,
   input  wire logic [TIME_W-1:0]    req_time_ms,
   input  wire logic [PAY_W-1:0]     req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [PAY_W-1:0]     rsp_cur_payload,
   output logic      [TIME_W-1:0]    rsp_cur_time_ms,
   output logic                      rsp_cur_valid,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REG_W-1:0]  delay_ff, stale_ff;
   logic [REG_W:0]    limit;
   logic [TIME_W-1:0] frame_ff, frame_in;
   logic              held_valid_ff, held_valid_in;
   logic [TIME_W-1:0] held_time_ff, held_time_in;
   logic [PAY_W-1:0]  held_pay_ff, held_pay_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PAY_W-1:0]  rsp_pay_ff, rsp_pay_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic              rsp_cv_ff, rsp_cv_in;

   logic              accept, push, full, pop, head_ready, stale, out_free;
   cell_cmd_type      cmd;
   logic [QUEUE_DEPTH-1:0] load_en;
   logic [TIME_W-1:0] cell_stamp [QUEUE_DEPTH];
   logic [PAY_W-1:0]  cell_pay   [QUEUE_DEPTH];

   // Configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         stale_ff <= STALE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DELAY) delay_ff <= csr_wdata;
         if (csr_index == CSR_STALE) stale_ff <= csr_wdata;
      end
   end

   assign limit = {1'b0, delay_ff} + {1'b0, stale_ff};

   // Request side
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_type == REQ_PUSH);
   assign full      = (cnt_ff == FULL_CNT);

   assign head_ready = (cnt_ff != '0) &&
      (({1'b0, cell_stamp[0]} + {{(TIME_W-REG_W+1){1'b0}}, delay_ff}) <= {1'b0, frame_ff});
   assign pop = (state_ff == ST_DRAIN) && head_ready;

   assign stale = held_valid_ff &&
      ({2'b00, frame_ff} > ({2'b00, held_time_ff} + {{(TIME_W-REG_W+1){1'b0}}, limit}));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Cell chain
   assign cmd.shift = pop || (push && full);
   assign cmd.stamp = req_time_ms;
   assign cmd.pay   = req_payload;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [TIME_W-1:0] up_stamp;
      logic [PAY_W-1:0]  up_pay;

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign up_stamp = cell_stamp[i];
         assign up_pay   = cell_pay[i];
      end else begin : g_mid
         assign up_stamp = cell_stamp[i+1];
         assign up_pay   = cell_pay[i+1];
      end

      // full push writes the tail after the shift; otherwise the first free slot
      assign load_en[i] = push && (full ? (i == QUEUE_DEPTH - 1) : (cnt_ff == CNT_W'(i)));

      tsdq_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .load_en  (load_en[i]),
         .up_stamp (up_stamp),
         .up_pay   (up_pay),
         .stamp    (cell_stamp[i]),
         .pay      (cell_pay[i])
      );
   end

   // Control
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      frame_in      = frame_ff;
      held_valid_in = held_valid_ff;
      held_time_in  = held_time_ff;
      held_pay_in   = held_pay_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pay_in    = rsp_pay_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_cv_in     = rsp_cv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (push && !full) begin
               cnt_in = cnt_ff + CNT_ONE;
            end
            if (accept && (req_type == REQ_FRAME)) begin
               frame_in = req_time_ms;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (head_ready) begin
               held_valid_in = 1'b1;
               held_time_in  = cell_stamp[0];
               held_pay_in   = cell_pay[0];
               cnt_in        = cnt_ff - CNT_ONE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (held_valid_ff && !stale) begin
                  rsp_pay_in  = held_pay_ff;
                  rsp_time_in = held_time_ff;
                  rsp_cv_in   = 1'b1;
               end else begin
                  rsp_pay_in  = '0;
                  rsp_time_in = '0;
                  rsp_cv_in   = 1'b0;
               end
               if (stale) begin
                  held_valid_in = 1'b0;
                  held_time_in  = '0;
                  held_pay_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         held_valid_ff <= 1'b0;
         held_time_ff  <= '0;
         held_pay_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         held_valid_ff <= held_valid_in;
         held_time_ff  <= held_time_in;
         held_pay_ff   <= held_pay_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_time_ff <= rsp_time_in;
      rsp_cv_ff   <= rsp_cv_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cur_payload = rsp_pay_ff;
   assign rsp_cur_time_ms = rsp_time_ff;
   assign rsp_cur_valid   = rsp_cv_ff;

   // Checks
   `CHK_NEXT(a_pop_count, clock, reset, pop, cnt_ff == $past(cnt_ff) - CNT_ONE)
   `CHK_NEXT(a_pop_held, clock, reset, pop, held_valid_ff)
   `CHK_NEXT(a_full_push, clock, reset, push && full, cnt_ff == FULL_CNT)
   `CHK_NEXT(a_finish_rsp, clock, reset, (state_ff == ST_FINISH) && out_free,
             rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timestamp delay release queue unit.
// Push and frame requests go in, mostly under random sender and receiver stalls.
// Each accepted request updates a software copy of the queue and held payload.
// Each response is checked field by field against the oldest predicted frame
// answer. Both timing registers are swept across their extremes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import tsdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 1000;
   localparam int PHASE_ITEMS   = 340;
   localparam logic [TIME_W-1:0] MAX_TIME = '1;

   typedef struct {
      logic [PAY_W-1:0]  pay;
      logic [TIME_W-1:0] stamp;
      logic              valid;
   } frame_answer_type;

   // Software copy of the release queue; predicts each frame answer.
   class release_queue_model;
      logic [TIME_W-1:0] stamps [DEPTH];
      logic [PAY_W-1:0]  handles [DEPTH];
      int                head;
      int                count;
      logic [TIME_W-1:0] held_stamp;
      logic [PAY_W-1:0]  held_handle;
      logic              held_valid;
      logic [REG_W-1:0]  delay_ms;
      logic [REG_W-1:0]  stale_ms;
      frame_answer_type  pending_frames [$];
      int                errors;

      function new();
         head        = 0;
         count       = 0;
         held_stamp  = '0;
         held_handle = '0;
         held_valid  = 1'b0;
         delay_ms    = '0;
         stale_ms    = STALE_RESET;
         errors      = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
         if (idx == CSR_DELAY) begin
            delay_ms = val;
         end else if (idx == CSR_STALE) begin
            stale_ms = val;
         end
      endfunction

      function void note_request(logic kind, logic [TIME_W-1:0] t, logic [PAY_W-1:0] pay);
         logic [63:0]      ready_at;
         logic [63:0]      stale_at;
         frame_answer_type ans;
         if (kind == REQ_PUSH) begin
            // full queue drops its oldest entry first
            if (count == DEPTH) begin
               head = (head + 1) % DEPTH;
               count--;
            end
            stamps[(head + count) % DEPTH]  = t;
            handles[(head + count) % DEPTH] = pay;
            count++;
         end else begin
            while (count > 0) begin
               ready_at = 64'(stamps[head]) + 64'(delay_ms);
               if (ready_at > 64'(t)) break;
               held_stamp  = stamps[head];
               held_handle = handles[head];
               held_valid  = 1'b1;
               head        = (head + 1) % DEPTH;
               count--;
            end
            // sums kept wide so a late stamp never wraps
            stale_at = 64'(held_stamp) + 64'(delay_ms) + 64'(stale_ms);
            if (held_valid && 64'(t) > stale_at) begin
               held_valid  = 1'b0;
               held_handle = '0;
               held_stamp  = '0;
            end
            ans.pay   = held_valid ? held_handle : '0;
            ans.stamp = held_valid ? held_stamp : '0;
            ans.valid = held_valid;
            pending_frames.push_back(ans);
         end
      endfunction

      function void check_result(logic [PAY_W-1:0] pay, logic [TIME_W-1:0] t, logic v);
         frame_answer_type want;
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected response payload %h time %h valid %b",
                     $time, pay, t, v);
            errors++;
         end else begin
            want = pending_frames.pop_front();
            if (pay !== want.pay) begin
               $display("%0t: cur_payload expected %h actual %h", $time, want.pay, pay);
               errors++;
            end
            if (t !== want.stamp) begin
               $display("%0t: cur_time_ms expected %h actual %h", $time, want.stamp, t);
               errors++;
            end
            if (v !== want.valid) begin
               $display("%0t: cur_valid expected %b actual %b", $time, want.valid, v);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return pending_frames.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_type = REQ_PUSH;
   logic [TIME_W-1:0]    req_time_ms = '0;
   logic [PAY_W-1:0]     req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PAY_W-1:0]     rsp_cur_payload;
   logic [TIME_W-1:0]    rsp_cur_time_ms;
   logic                 rsp_cur_valid;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DELAY;
   logic [REG_W-1:0]     csr_wdata = '0;

   release_queue_model   model;
   int                   send_idle_pct = 0;
   int                   rsp_idle_pct = 0;
   int                   quiet_cycles = 0;
   logic [TIME_W-1:0]    now_ms = '0;

   timestamp_delay_release_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_time_ms     (req_time_ms),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cur_payload (rsp_cur_payload),
      .rsp_cur_time_ms (rsp_cur_time_ms),
      .rsp_cur_valid   (rsp_cur_valid),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            model.check_result(rsp_cur_payload, rsp_cur_time_ms, rsp_cur_valid);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [TIME_W-1:0] random_time();
      return TIME_W'({$urandom(), $urandom()});
   endfunction

   // Valid stays high across back-to-back requests; lowered only for a gap.
   task automatic send_request(input logic kind, input logic [TIME_W-1:0] t,
                               input logic [PAY_W-1:0] pay);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_time_ms <= t;
      req_payload <= pay;
      do @(posedge clock); while (req_stall);
      model.note_request(kind, t, pay);
   endtask

   // Wait out every pending frame answer, then let the datapath go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (model.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_timing(input logic [REG_W-1:0] delay, input logic [REG_W-1:0] stale);
      csr_valid <= 1'b1;
      csr_index <= CSR_DELAY;
      csr_wdata <= delay;
      do @(posedge clock); while (!csr_ready);
      model.set_reg(CSR_DELAY, delay);
      csr_index <= CSR_STALE;
      csr_wdata <= stale;
      do @(posedge clock); while (!csr_ready);
      model.set_reg(CSR_STALE, stale);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int items, input int send_pct, input int rsp_pct);
      int                step_max;
      logic              kind;
      logic [TIME_W-1:0] t;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      step_max = 20 + int'(model.stale_ms) / 8 + int'(model.delay_ms) / 16;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(299) == 0) settle();
         // occasional long jump lets the held payload go stale
         if ($urandom_range(39) == 0) begin
            now_ms += TIME_W'($urandom_range(0, 2 * (int'(model.delay_ms) +
                                            int'(model.stale_ms)) + 3000));
         end else begin
            now_ms += TIME_W'($urandom_range(0, step_max));
         end
         kind = ($urandom_range(99) < 55) ? REQ_PUSH : REQ_FRAME;
         if ($urandom_range(24) == 0) begin
            t = random_time();
         end else if (kind == REQ_PUSH) begin
            t = now_ms - TIME_W'($urandom_range(0, int'(model.delay_ms) + 16));
         end else begin
            t = now_ms;
         end
         send_request(kind, t, $urandom());
      end
   endtask

   initial begin
      logic [REG_W-1:0] delay;
      logic [REG_W-1:0] stale;
      model = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset timing: delay 0, stale timeout 1000
      send_request(REQ_FRAME, '0, $urandom());
      send_request(REQ_PUSH, '0, '0);
      send_request(REQ_PUSH, MAX_TIME, '1);
      send_request(REQ_FRAME, '0, $urandom());
      send_request(REQ_FRAME, MAX_TIME, $urandom());
      // overflow drops the two oldest
      for (int i = 0; i < DEPTH + 2; i++) begin
         send_request(REQ_PUSH, TIME_W'(100 + i), PAY_W'(32'hA500_0000 + i));
      end
      send_request(REQ_FRAME, TIME_W'(200), $urandom());
      send_request(REQ_FRAME, TIME_W'(2000), $urandom());

      settle();
      set_timing('1, '0);
      send_request(REQ_PUSH, TIME_W'(100), 32'h5A5A_5A5A);
      send_request(REQ_FRAME, TIME_W'(65634), $urandom());
      send_request(REQ_FRAME, TIME_W'(65635), $urandom());
      send_request(REQ_FRAME, TIME_W'(65636), $urandom());
      // stamp plus delay must not wrap past the top of the time range
      send_request(REQ_PUSH, MAX_TIME - TIME_W'(5), 32'h1234_5678);
      send_request(REQ_FRAME, MAX_TIME, $urandom());

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: begin
               delay = '0;
               stale = '0;
            end
            1: begin
               delay = '1;
               stale = '1;
            end
            3: begin
               delay = REG_W'($urandom_range(0, 300));
               stale = REG_W'($urandom_range(0, 300));
            end
            4: begin
               delay = '0;
               stale = '1;
            end
            default: begin
               delay = REG_W'($urandom());
               stale = REG_W'($urandom());
            end
         endcase
         set_timing(delay, stale);
         if (p == 5) now_ms = MAX_TIME - TIME_W'($urandom_range(0, 200000));
         case (p / 2)
            0: run_phase(PHASE_ITEMS, 37, 64);
            1: run_phase(PHASE_ITEMS, 64, 37);
            default: run_phase(PHASE_ITEMS, 0, 0);
         endcase
      end

      settle();
      if (model.errors == 0 && model.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/tsdq_pkg.sv
src/tsdq_cell.sv
src/timestamp_delay_release_queue_unit.sv
bench/tb.sv
